FILE: design/vat_pkg.sv
// Shared constants, codes and types for the vertex affine transform block.
package vat_pkg;

  localparam int COORD_W  = 32;  // Q16.16 coordinate
  localparam int TRIG_W   = 16;  // Q2.14 cosine / sine
  localparam int RATIO_W  = 24;  // Q8.16 scale ratio
  localparam int MULT_W   = 25;  // signed multiplier coefficient
  localparam int PROD_W   = COORD_W + MULT_W;   // one product
  localparam int SUM_W    = PROD_W + 1;         // sum of two products
  localparam int ROT_SH   = 14;
  localparam int SCL_SH   = 16;
  localparam int RND_W    = SUM_W - ROT_SH;     // value after the narrower shift
  localparam int LANES    = 3;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Coefficient that turns a Q16.16 operand into a Q18.30 product unchanged.
  localparam logic signed [MULT_W-1:0] UNITY = MULT_W'(1 << ROT_SH);

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_ROTATE    = 2'd1,
    OP_SCALE     = 2'd2
  } op_mode_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    REG_OP_MODE     = 3'd0,
    REG_AXIS_SELECT = 3'd1,
    REG_OFFSET      = 3'd2,
    REG_COS_VALUE   = 3'd3,
    REG_SIN_VALUE   = 3'd4,
    REG_SCALE_RATIO = 3'd5
  } reg_index_t;

  localparam logic signed [TRIG_W-1:0] COS_RESET   = TRIG_W'(16384);
  localparam logic [RATIO_W-1:0]       RATIO_RESET = RATIO_W'(65536);

endpackage

FILE: design/vertex_affine_transform.sv
// Top level of the vertex affine transform: config registers and a four-stage pipeline.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one vertex per transaction:
//   x_in, y_in, z_in in signed Q16.16 and the last_vertex marker. The output
//   channel (out_valid / out_ready) returns one transformed vertex per input
//   transaction, in order, with last_out copied and overflow set when any
//   coordinate was clamped to the signed 32-bit range.
//   The APB-style port writes op_mode, axis_select, offset, cos_value,
//   sin_value and scale_ratio at byte addresses 0, 4, 8, 12, 16, 20; reads
//   return the stored values. Write it only while the pipeline is empty.
// Timing:
//   Four register stages: operand select, multiply, sum and round, saturate.
//   An accepted vertex moves through them to the outputs. Unless out_ready
//   stalls, one vertex is accepted per cycle, set by six parallel 32x25 multipliers.
// Reset: rst (synchronous) empties the pipeline and loads the identity setup
//   (translate on x by zero, cosine 1.0, sine 0, scale 1.0).
// Backpressure:
//   While out_ready is low, held stages keep their data; each stage advances
//   only into an empty or draining slot, so in_ready drops once the pipeline
//   is full and no transaction is lost or repeated.
module vertex_affine_transform (
  input  logic                              clk,
  input  logic                              rst,
  // input vertex channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [vat_pkg::COORD_W-1:0] x_in,
  input  logic signed [vat_pkg::COORD_W-1:0] y_in,
  input  logic signed [vat_pkg::COORD_W-1:0] z_in,
  input  logic                              last_vertex,
  // output vertex channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [vat_pkg::COORD_W-1:0] x_out,
  output logic signed [vat_pkg::COORD_W-1:0] y_out,
  output logic signed [vat_pkg::COORD_W-1:0] z_out,
  output logic                              last_out,
  output logic                              overflow,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vat_pkg::ADDR_W-1:0]        paddr,
  input  logic [vat_pkg::DATA_W-1:0]        pwdata,
  output logic [vat_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int CW = vat_pkg::COORD_W;
  localparam int MW = vat_pkg::MULT_W;
  localparam int PW = vat_pkg::PROD_W;
  localparam int SW = vat_pkg::SUM_W;
  localparam int RW = vat_pkg::RND_W;
  localparam int TW = vat_pkg::TRIG_W;
  localparam int NL = vat_pkg::LANES;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [1:0]                      op_mode;
  logic [1:0]                      axis_select;
  logic signed [CW-1:0]            offset;
  logic signed [TW-1:0]            cos_value;
  logic signed [TW-1:0]            sin_value;
  logic [vat_pkg::RATIO_W-1:0]     scale_ratio;
  logic [2:0]                      reg_idx;
  logic                            cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[vat_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode     <= vat_pkg::OP_TRANSLATE;
      axis_select <= vat_pkg::AXIS_X;
      offset      <= '0;
      cos_value   <= vat_pkg::COS_RESET;
      sin_value   <= '0;
      scale_ratio <= vat_pkg::RATIO_RESET;
    end else if (cfg_write) begin
      // Addresses past the last register fall through and are dropped.
      case (reg_idx)
        vat_pkg::REG_OP_MODE:     op_mode     <= pwdata[1:0];
        vat_pkg::REG_AXIS_SELECT: axis_select <= pwdata[1:0];
        vat_pkg::REG_OFFSET:      offset      <= pwdata;
        vat_pkg::REG_COS_VALUE:   cos_value   <= pwdata[TW-1:0];
        vat_pkg::REG_SIN_VALUE:   sin_value   <= pwdata[TW-1:0];
        vat_pkg::REG_SCALE_RATIO: scale_ratio <= pwdata[vat_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      vat_pkg::REG_OP_MODE:     prdata = {30'd0, op_mode};
      vat_pkg::REG_AXIS_SELECT: prdata = {30'd0, axis_select};
      vat_pkg::REG_OFFSET:      prdata = offset;
      vat_pkg::REG_COS_VALUE:   prdata = {{(vat_pkg::DATA_W-TW){cos_value[TW-1]}}, cos_value};
      vat_pkg::REG_SIN_VALUE:   prdata = {{(vat_pkg::DATA_W-TW){sin_value[TW-1]}}, sin_value};
      vat_pkg::REG_SCALE_RATIO:
        prdata = {{(vat_pkg::DATA_W-vat_pkg::RATIO_W){1'b0}}, scale_ratio};
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage flow control: a stage advances when it is empty or its
  // successor advances.
  // ---------------------------------------------------------------------
  logic v0, v1, v2, v3;
  logic en0, en1, en2, en3;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_ready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // ---------------------------------------------------------------------
  // Operand select. Every lane computes a*ma + b*mb in Q18.30 (Q24.32 for scale),
  // then rounds and shifts. Pass and translate use the unity coefficient so the
  // shift returns the exact sum; rotate signs are folded into the coefficients.
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] crd      [NL];
  logic signed [CW-1:0] sel_a    [NL];
  logic signed [CW-1:0] sel_b    [NL];
  logic signed [MW-1:0] sel_ma   [NL];
  logic signed [MW-1:0] sel_mb   [NL];
  logic                 sel_scl;
  logic signed [MW-1:0] c_ext, s_ext, s_neg, r_ext;

  assign crd[0] = x_in;
  assign crd[1] = y_in;
  assign crd[2] = z_in;
  assign c_ext  = {{(MW-TW){cos_value[TW-1]}}, cos_value};
  assign s_ext  = {{(MW-TW){sin_value[TW-1]}}, sin_value};
  assign s_neg  = -s_ext;
  assign r_ext  = {{(MW-vat_pkg::RATIO_W){1'b0}}, scale_ratio};

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      sel_a[i]  = crd[i];
      sel_ma[i] = vat_pkg::UNITY;
      sel_b[i]  = '0;
      sel_mb[i] = '0;
    end
    sel_scl = 1'b0;
    case (op_mode)
      vat_pkg::OP_TRANSLATE: begin
        case (axis_select)
          vat_pkg::AXIS_X: begin sel_b[0] = offset; sel_mb[0] = vat_pkg::UNITY; end
          vat_pkg::AXIS_Y: begin sel_b[1] = offset; sel_mb[1] = vat_pkg::UNITY; end
          vat_pkg::AXIS_Z: begin sel_b[2] = offset; sel_mb[2] = vat_pkg::UNITY; end
          default: ;
        endcase
      end
      vat_pkg::OP_ROTATE: begin
        case (axis_select)
          vat_pkg::AXIS_X: begin
            sel_a[1] = y_in; sel_ma[1] = c_ext; sel_b[1] = z_in; sel_mb[1] = s_neg;
            sel_a[2] = y_in; sel_ma[2] = s_ext; sel_b[2] = z_in; sel_mb[2] = c_ext;
          end
          vat_pkg::AXIS_Y: begin
            sel_a[0] = x_in; sel_ma[0] = c_ext; sel_b[0] = z_in; sel_mb[0] = s_ext;
            sel_a[2] = z_in; sel_ma[2] = c_ext; sel_b[2] = x_in; sel_mb[2] = s_neg;
          end
          vat_pkg::AXIS_Z: begin
            sel_a[0] = x_in; sel_ma[0] = c_ext; sel_b[0] = y_in; sel_mb[0] = s_neg;
            sel_a[1] = x_in; sel_ma[1] = s_ext; sel_b[1] = y_in; sel_mb[1] = c_ext;
          end
          default: ;
        endcase
      end
      vat_pkg::OP_SCALE: begin
        // A zero ratio leaves the vertex as it is.
        if (scale_ratio != '0) begin
          for (int i = 0; i < NL; i++) sel_ma[i] = r_ext;
          sel_scl = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Stage 0: registered operands
  logic signed [CW-1:0] s0_a  [NL];
  logic signed [CW-1:0] s0_b  [NL];
  logic signed [MW-1:0] s0_ma [NL];
  logic signed [MW-1:0] s0_mb [NL];
  logic                 s0_scl, s0_last;

  always_ff @(posedge clk) begin
    if (en0) begin
      for (int i = 0; i < NL; i++) begin
        s0_a[i]  <= sel_a[i];
        s0_b[i]  <= sel_b[i];
        s0_ma[i] <= sel_ma[i];
        s0_mb[i] <= sel_mb[i];
      end
      s0_scl  <= sel_scl;
      s0_last <= last_vertex;
    end
  end

  // Stage 1: products
  logic signed [PW-1:0] s1_pa [NL];
  logic signed [PW-1:0] s1_pb [NL];
  logic                 s1_scl, s1_last;

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < NL; i++) begin
        s1_pa[i] <= s0_a[i] * s0_ma[i];
        s1_pb[i] <= s0_b[i] * s0_mb[i];
      end
      s1_scl  <= s0_scl;
      s1_last <= s0_last;
    end
  end

  // Stage 2: sum, round half up, floor shift
  logic signed [SW-1:0] sum_r [NL];
  logic signed [RW-1:0] shv   [NL];
  logic signed [SW-1:0] rnd;
  logic signed [RW-1:0] s2_v  [NL];
  logic                 s2_last;

  assign rnd = s1_scl ? SW'(1 << (vat_pkg::SCL_SH - 1)) : SW'(1 << (vat_pkg::ROT_SH - 1));

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      sum_r[i] = SW'(s1_pa[i]) + SW'(s1_pb[i]) + rnd;
      shv[i]   = s1_scl ? {{(vat_pkg::SCL_SH - vat_pkg::ROT_SH){sum_r[i][SW-1]}},
                           sum_r[i][SW-1:vat_pkg::SCL_SH]}
                        : sum_r[i][SW-1:vat_pkg::ROT_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < NL; i++) s2_v[i] <= shv[i];
      s2_last <= s1_last;
    end
  end

  // Stage 3: saturate into the output register
  logic signed [CW-1:0] sat_v [NL];
  logic [NL-1:0]        sat_hit;
  logic signed [CW-1:0] s3_v  [NL];
  logic                 s3_last, s3_ovf;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      // In range when every bit above the coordinate sign matches it.
      sat_hit[i] = !((&s2_v[i][RW-1:CW-1]) || !(|s2_v[i][RW-1:CW-1]));
      if (!sat_hit[i])
        sat_v[i] = s2_v[i][CW-1:0];
      else if (s2_v[i][RW-1])
        sat_v[i] = {1'b1, {(CW-1){1'b0}}};
      else
        sat_v[i] = {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < NL; i++) s3_v[i] <= sat_v[i];
      s3_last <= s2_last;
      s3_ovf  <= |sat_hit;
    end
  end

  assign out_valid = v3;
  assign x_out     = s3_v[0];
  assign y_out     = s3_v[1];
  assign z_out     = s3_v[2];
  assign last_out  = s3_last;
  assign overflow  = s3_ovf;

endmodule

FILE: tb/vertex_transform_checker.sv
// Checker for the vertex affine transform: tracks register writes, predicts and compares results.
module vertex_transform_checker
  import vat_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [COORD_W-1:0] x_in,
  input  logic signed [COORD_W-1:0] y_in,
  input  logic signed [COORD_W-1:0] z_in,
  input  logic                      last_vertex,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [COORD_W-1:0] x_out,
  input  logic signed [COORD_W-1:0] y_out,
  input  logic signed [COORD_W-1:0] z_out,
  input  logic                      last_out,
  input  logic                      overflow,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output int                        errors,
  output int                        pending
);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
    logic                      ovf;
  } vertex_t;

  localparam longint COORD_HI = 64'sd2147483647;
  localparam longint COORD_LO = -64'sd2147483648;
  localparam longint ROT_HALF = 64'sd1 <<< (ROT_SH - 1);
  localparam longint SCL_HALF = 64'sd1 <<< (SCL_SH - 1);

  logic [1:0]                op_q;
  logic [1:0]                axis_q;
  logic signed [COORD_W-1:0] offset_q;
  logic signed [TRIG_W-1:0]  cos_q;
  logic signed [TRIG_W-1:0]  sin_q;
  logic [RATIO_W-1:0]        ratio_q;
  vertex_t                   vertex_q[$];
  int                        result_count;

  function automatic logic signed [COORD_W-1:0] clamp(input longint v, inout logic ovf);
    longint r;
    r = v;
    if (v > COORD_HI) begin
      r = COORD_HI;
      ovf = 1'b1;
    end else if (v < COORD_LO) begin
      r = COORD_LO;
      ovf = 1'b1;
    end
    return r[COORD_W-1:0];
  endfunction

  // round half up, floor shift
  function automatic longint rot_round(input longint sum);
    return (sum + ROT_HALF) >>> ROT_SH;
  endfunction

  function automatic vertex_t transform_vertex(input longint x, input longint y,
                                               input longint z, input logic lv);
    vertex_t r;
    longint  c;
    longint  s;
    longint  k;
    logic    ovf;
    c = cos_q;
    s = sin_q;
    k = ratio_q;
    ovf = 1'b0;
    r.x = x[COORD_W-1:0];
    r.y = y[COORD_W-1:0];
    r.z = z[COORD_W-1:0];
    r.last = lv;
    case (op_q)
      OP_TRANSLATE: begin
        case (axis_q)
          AXIS_X: r.x = clamp(x + offset_q, ovf);
          AXIS_Y: r.y = clamp(y + offset_q, ovf);
          AXIS_Z: r.z = clamp(z + offset_q, ovf);
          default: ;
        endcase
      end
      OP_ROTATE: begin
        case (axis_q)
          AXIS_X: begin
            r.y = clamp(rot_round(y * c - z * s), ovf);
            r.z = clamp(rot_round(y * s + z * c), ovf);
          end
          AXIS_Y: begin
            r.x = clamp(rot_round(x * c + z * s), ovf);
            r.z = clamp(rot_round(z * c - x * s), ovf);
          end
          AXIS_Z: begin
            r.x = clamp(rot_round(x * c - y * s), ovf);
            r.y = clamp(rot_round(x * s + y * c), ovf);
          end
          default: ;
        endcase
      end
      OP_SCALE: begin
        if (ratio_q != '0) begin
          r.x = clamp((x * k + SCL_HALF) >>> SCL_SH, ovf);
          r.y = clamp((y * k + SCL_HALF) >>> SCL_SH, ovf);
          r.z = clamp((z * k + SCL_HALF) >>> SCL_SH, ovf);
        end
      end
      default: ;
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                             input logic [COORD_W-1:0] got);
    if (want !== got) begin
      if (errors < 10)
        $display("mismatch on %s in result %0d: expected %h, got %h",
                 name, result_count, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    vertex_t want;
    if (rst) begin
      op_q = OP_TRANSLATE;
      axis_q = AXIS_X;
      offset_q = '0;
      cos_q = COS_RESET;
      sin_q = '0;
      ratio_q = RATIO_RESET;
      vertex_q.delete();
      errors = 0;
      result_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[ADDR_W-1:2]))
          REG_OP_MODE:     op_q = pwdata[1:0];
          REG_AXIS_SELECT: axis_q = pwdata[1:0];
          REG_OFFSET:      offset_q = pwdata[COORD_W-1:0];
          REG_COS_VALUE:   cos_q = pwdata[TRIG_W-1:0];
          REG_SIN_VALUE:   sin_q = pwdata[TRIG_W-1:0];
          REG_SCALE_RATIO: ratio_q = pwdata[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          if (errors < 10)
            $display("result %0d arrived with no vertex outstanding", result_count);
          errors++;
        end else begin
          want = vertex_q.pop_front();
          check_field("x_out", want.x, x_out);
          check_field("y_out", want.y, y_out);
          check_field("z_out", want.z, z_out);
          check_field("last_out", COORD_W'(want.last), COORD_W'(last_out));
          check_field("overflow", COORD_W'(want.ovf), COORD_W'(overflow));
        end
        result_count++;
      end
      if (in_valid && in_ready)
        vertex_q.insert(vertex_q.size(), transform_vertex(x_in, y_in, z_in, last_vertex));
    end
    pending = vertex_q.size();
  end

endmodule

FILE: tb/tb_vertex_affine_transform.sv
// Testbench top for the vertex affine transform: stimulus, flow control and verdict.
module tb_vertex_affine_transform;
  import vat_pkg::*;

  // Run budget: ~620 vertices with sender gaps and receiver stalls stay far below this.
  localparam int LIMIT       = 200000;
  localparam int DRAIN_SLACK = 12;  // settling margin beyond the four-stage pipeline

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFFFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

  // Codes the package leaves undefined; the block must pass vertices through for them.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] AXIS_UNUSED = 2'd3;

  // First address past the register list; writes there must be ignored.
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'((REG_SCALE_RATIO + 1) * 4);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } vertex_in_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         axis;
    logic [COORD_W-1:0] offset;
    logic [TRIG_W-1:0]  cosv;
    logic [TRIG_W-1:0]  sinv;
    logic [RATIO_W-1:0] ratio;
  } xform_setup_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [COORD_W-1:0] x_in;
  logic signed [COORD_W-1:0] y_in;
  logic signed [COORD_W-1:0] z_in;
  logic                      last_vertex;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [COORD_W-1:0] x_out;
  logic signed [COORD_W-1:0] y_out;
  logic signed [COORD_W-1:0] z_out;
  logic                      last_out;
  logic                      overflow;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  int errors;
  int pending;
  int cycles = 0;
  int burst_left;

  vertex_affine_transform uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .x_in(x_in), .y_in(y_in), .z_in(z_in), .last_vertex(last_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .x_out(x_out), .y_out(y_out), .z_out(z_out),
    .last_out(last_out), .overflow(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  vertex_transform_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .x_in(x_in), .y_in(y_in), .z_in(z_in), .last_vertex(last_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .x_out(x_out), .y_out(y_out), .z_out(z_out),
    .last_out(last_out), .overflow(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run; a correct one never gets near this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: switch among always-ready, coin-flip, mostly-stalled and toggling
  // stretches so backpressure lands on every pipeline phase.
  initial begin : receiver
    int mode;
    int left;
    out_ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = 1'($urandom_range(0, 1));
        2: out_ready = ($urandom_range(0, 3) == 0);
        default: out_ready = ~out_ready;
      endcase
    end
  end

  function automatic logic [ADDR_W-1:0] reg_addr(input reg_index_t idx);
    return ADDR_W'(idx) << 2;
  endfunction

  // Setup + access phase; the register lands on the edge where pready is seen high.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apply_setup(input xform_setup_t s);
    write_reg(reg_addr(REG_OP_MODE), DATA_W'(s.op));
    write_reg(reg_addr(REG_AXIS_SELECT), DATA_W'(s.axis));
    write_reg(reg_addr(REG_OFFSET), DATA_W'(s.offset));
    write_reg(reg_addr(REG_COS_VALUE), DATA_W'(s.cosv));
    write_reg(reg_addr(REG_SIN_VALUE), DATA_W'(s.sinv));
    write_reg(reg_addr(REG_SCALE_RATIO), DATA_W'(s.ratio));
  endtask

  // Present one vertex and hold it until the transaction completes. Bursts of
  // back-to-back vertices alternate with random gaps, some bursts long and gapless.
  task automatic send_vertex(input vertex_in_t v);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    x_in = v.x;
    y_in = v.y;
    z_in = v.z;
    last_vertex = v.last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, drain every outstanding vertex, then let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  function automatic vertex_in_t corner_vertex(input int k);
    vertex_in_t v;
    case (k % 4)
      0: v = '{COORD_MAX, COORD_MAX, COORD_MAX, 1'b0};
      1: v = '{COORD_MIN, COORD_MIN, COORD_MIN, 1'b1};
      2: v = '{COORD_MAX, COORD_MIN, -32'sd1, 1'b0};
      default: v = '{COORD_MIN, COORD_MAX, 32'sh00008000, 1'b1};
    endcase
    return v;
  endfunction

  // Mix full-range words with small values so rotate and scale don't always clamp.
  function automatic logic signed [COORD_W-1:0] random_coord();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $urandom_range(0, 2097152) - 1048576;
      7:          v = COORD_MAX;
      8:          v = COORD_MIN;
      default:    v = $urandom_range(0, 15) - 8;
    endcase
    return v;
  endfunction

  function automatic vertex_in_t random_vertex();
    vertex_in_t v;
    v.x = random_coord();
    v.y = random_coord();
    v.z = random_coord();
    v.last = ($urandom_range(0, 7) == 0);
    return v;
  endfunction

  function automatic xform_setup_t reset_setup();
    return '{OP_TRANSLATE, AXIS_X, '0, COS_RESET, '0, RATIO_RESET};
  endfunction

  // Corner settings: saturating offsets, raw 16-bit trig beyond +/-1.0, the
  // largest and the zero ratio, and the undefined operation and axis codes.
  function automatic xform_setup_t directed_setup(input int p);
    xform_setup_t s;
    s = reset_setup();
    case (p)
      1: begin s.axis = AXIS_Y; s.offset = 32'h7FFFFFFF; end
      2: begin s.axis = AXIS_Z; s.offset = 32'h80000000; end
      3: begin s.op = OP_ROTATE; s.axis = AXIS_X; s.cosv = 16'h8000; s.sinv = 16'h7FFF; end
      4: begin s.op = OP_ROTATE; s.axis = AXIS_Y; s.cosv = 16'h4000; s.sinv = 16'hC000; end
      5: begin s.op = OP_ROTATE; s.axis = AXIS_Z; s.cosv = 16'hC000; s.sinv = 16'h4000; end
      6: begin s.op = OP_SCALE; s.ratio = 24'hFFFFFF; end
      7: begin s.op = OP_SCALE; s.ratio = '0; end
      8: begin s.op = OP_UNUSED; s.offset = 32'h12345678; end
      9: begin s.axis = AXIS_UNUSED; s.offset = 32'h7FFFFFFF; end
      default: ;
    endcase
    return s;
  endfunction

  // Cycle through the operations; now and then pick an undefined code or an extreme.
  function automatic xform_setup_t random_setup(input int p);
    xform_setup_t s;
    int           r;
    s.op = ($urandom_range(0, 9) == 0) ? OP_UNUSED : 2'(p % 3);
    s.axis = ($urandom_range(0, 9) == 0) ? AXIS_UNUSED : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0:       s.offset = 32'h7FFFFFFF;
      1:       s.offset = 32'h80000000;
      2, 3:    s.offset = $urandom;
      default: begin r = $urandom_range(0, 33554432) - 16777216; s.offset = r; end
    endcase
    case ($urandom_range(0, 7))
      0: begin s.cosv = TRIG_W'($urandom); s.sinv = TRIG_W'($urandom); end
      1: begin s.cosv = 16'h4000; s.sinv = 16'hC000; end
      default: begin
        r = $urandom_range(0, 32768) - 16384;
        s.cosv = r[TRIG_W-1:0];
        r = $urandom_range(0, 32768) - 16384;
        s.sinv = r[TRIG_W-1:0];
      end
    endcase
    case ($urandom_range(0, 9))
      0:       s.ratio = '0;
      1:       s.ratio = 24'hFFFFFF;
      2:       s.ratio = RATIO_W'($urandom);
      default: s.ratio = RATIO_W'($urandom_range(1, 262144));
    endcase
    return s;
  endfunction

  initial begin : stimulus
    int p;
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    x_in = '0;
    y_in = '0;
    z_in = '0;
    last_vertex = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: run the reset setup untouched first, then each corner setting.
    for (p = 0; p < 10; p++) begin
      if (p > 0)
        apply_setup(directed_setup(p));
      if (p == 8)
        write_reg(SPARE_ADDR, $urandom);
      for (i = 0; i < 2; i++)
        send_vertex(corner_vertex(2 * p + i));
      wait_idle();
    end

    // Random: twelve settings, fifty vertices each, reconfigured only when drained.
    for (p = 0; p < 12; p++) begin
      apply_setup(random_setup(p));
      for (i = 0; i < 50; i++)
        send_vertex(random_vertex());
      wait_idle();
    end

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
design/vat_pkg.sv
design/vertex_affine_transform.sv
tb/vertex_transform_checker.sv
tb/tb_vertex_affine_transform.sv
